/* rtl/core/spq_pkg.sv */
// shared types and codes for the sorted priority queue
package spq_pkg;

	typedef enum logic [1:0] {
		FUNC_ENQ  = 2'd0,
		FUNC_DEQ  = 2'd1,
		FUNC_PEEK = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam int VALUE_W = 32;
	localparam int RANK_W  = 16;
	localparam int FILL_W  = 5;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RANK_W-1:0]  rank;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

/* rtl/core/spq_cell.sv */
// one slot of the sorted chain: keep, take the new entry or shift from a neighbor
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  logic               left_le,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	input  spq_pkg::entry_t    new_entry,
	output spq_pkg::entry_t    entry,
	output logic               le
);

	spq_pkg::entry_t entry_q;

	assign entry = entry_q;
	assign le    = occupied && (entry_q.rank <= new_entry.rank);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!le) begin
				entry_q <= left_le ? new_entry : left_entry;
			end
		end else if (ctrl.del) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* rtl/core/sorted_priority_queue_core.sv */
// top level of the sorted priority queue built from a chain of slot cells
//
// input stream: one beat carries one operation, s_tuser selects it
// (enqueue, dequeue, peek; code 3 does nothing), s_tdata carries the
// data word and its priority for an enqueue.
// output stream: one result beat per input beat, m_tuser gives the status
// (ok, empty, full and dropped), m_tdata the front word and priority for a
// dequeue or peek (zero otherwise) and the fill count after the operation.
// entries leave in ascending priority number; equal priorities leave in
// arrival order.
// the result is registered: it is on m_tvalid in the cycle after the input beat is taken.
// throughput: one beat per cycle unless the receiver stalls; every slot cell
// compares and shifts in the same cycle, so an insert or a removal is done at once.
// the result register lets a new beat in while a result waits, as long as
// that result is taken in the same cycle; a stalled receiver holds
// s_tready low.
// reset empties the queue and drops any pending result; slot contents
// are not cleared.
module sorted_priority_queue_core #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // in_value[31:0], in_rank[47:32]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // out_value[31:0], out_rank[47:32], fill[52:48], zero
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CNTW = (CW > spq_pkg::FILL_W) ? CW : spq_pkg::FILL_W;

	logic [CNTW-1:0]     count_q;
	logic [CNTW-1:0]     count_nxt;
	logic                out_valid_q;
	spq_pkg::status_t    status_q;
	spq_pkg::entry_t     front_q;
	logic [CNTW-1:0]     fill_q;

	spq_pkg::entry_t     new_entry;
	spq_pkg::entry_t     cell_entry [DEPTH];
	logic                cell_le    [DEPTH];
	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::status_t    status_nxt;
	spq_pkg::entry_t     front_nxt;
	logic                accept;
	logic                full;
	logic                empty;

	assign new_entry.value = s_tdata[31:0];
	assign new_entry.rank  = s_tdata[47:32];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q >= CNTW'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		ctrl       = '0;
		status_nxt = spq_pkg::ST_OK;
		front_nxt  = '0;
		count_nxt  = count_q;
		case (spq_pkg::func_t'(s_tuser))
			spq_pkg::FUNC_ENQ: begin
				if (full) begin
					status_nxt = spq_pkg::ST_FULL;
				end else begin
					ctrl.ins  = accept;
					count_nxt = count_q + CNTW'(1);
				end
			end
			spq_pkg::FUNC_DEQ: begin
				if (empty) begin
					status_nxt = spq_pkg::ST_EMPTY;
				end else begin
					ctrl.del  = accept;
					front_nxt = cell_entry[0];
					count_nxt = count_q - CNTW'(1);
				end
			end
			spq_pkg::FUNC_PEEK: begin
				if (empty) begin
					status_nxt = spq_pkg::ST_EMPTY;
				end else begin
					front_nxt = cell_entry[0];
				end
			end
			default: begin
				status_nxt = spq_pkg::ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (count_q > CNTW'(i)),
			.left_le     ((i == 0) ? 1'b1 : cell_le[(i == 0) ? 0 : i - 1]),
			.left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
			.right_entry ((i == DEPTH - 1) ? new_entry
			              : cell_entry[(i == DEPTH - 1) ? i : i + 1]),
			.new_entry   (new_entry),
			.entry       (cell_entry[i]),
			.le          (cell_le[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			front_q  <= front_nxt;
			fill_q   <= count_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, fill_q[spq_pkg::FILL_W-1:0], front_q.rank, front_q.value};

endmodule

/* rtl/core/spq_checker.sv */
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no pending result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("undefined status code");

	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == spq_pkg::ST_EMPTY |-> m_tdata[52:0] == '0)
		else $error("empty result with data or nonzero fill");

	a_full_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == spq_pkg::ST_FULL |-> m_tdata[47:0] == '0)
		else $error("dropped enqueue returned data");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* dv/testbench.sv */
// self-checking testbench for the sorted priority queue core
`timescale 1ns / 100ps

module testbench;

	localparam int          QUEUE_DEPTH    = 16;
	localparam int          WATCHDOG_LIMIT = 1000;
	localparam logic [1:0]  FUNC_NOP       = 2'd3;

	typedef struct {
		spq_pkg::status_t           status;
		logic [spq_pkg::VALUE_W-1:0] value;
		logic [spq_pkg::RANK_W-1:0]  rank;
		logic [spq_pkg::FILL_W-1:0]  fill;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // in_value[31:0], in_rank[47:32]
	logic [1:0]  s_tuser;  // func[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;  // out_value[31:0], out_rank[47:32], fill[52:48], zero
	logic [1:0]  m_tuser;  // status[1:0]

	logic [spq_pkg::VALUE_W-1:0] slot_value [QUEUE_DEPTH];
	logic [spq_pkg::RANK_W-1:0]  slot_rank  [QUEUE_DEPTH];
	int                          stored;
	result_t                     pending_results [$];
	int                          fail_count;
	int                          stall_cycles;
	int                          tx_idle_pct;
	int                          rx_idle_pct;

	sorted_priority_queue_core #(
		.DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	function automatic result_t queue_op(logic [1:0] op, logic [spq_pkg::VALUE_W-1:0] val,
			logic [spq_pkg::RANK_W-1:0] rank);
		result_t r;
		int      pos;
		int      k;
		r.status = spq_pkg::ST_OK;
		r.value  = '0;
		r.rank   = '0;
		if (op == spq_pkg::FUNC_ENQ) begin
			if (stored >= QUEUE_DEPTH) begin
				r.status = spq_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < stored && slot_rank[pos] <= rank)
					pos++;
				for (k = stored; k > pos; k--) begin
					slot_value[k] = slot_value[k-1];
					slot_rank[k]  = slot_rank[k-1];
				end
				slot_value[pos] = val;
				slot_rank[pos]  = rank;
				stored++;
			end
		end else if (op == spq_pkg::FUNC_DEQ || op == spq_pkg::FUNC_PEEK) begin
			if (stored == 0) begin
				r.status = spq_pkg::ST_EMPTY;
			end else begin
				r.value = slot_value[0];
				r.rank  = slot_rank[0];
				if (op == spq_pkg::FUNC_DEQ) begin
					for (k = 0; k + 1 < stored; k++) begin
						slot_value[k] = slot_value[k+1];
						slot_rank[k]  = slot_rank[k+1];
					end
					stored--;
				end
			end
		end
		r.fill = stored[spq_pkg::FILL_W-1:0];
		return r;
	endfunction

	task automatic send_beat(input logic [1:0] op, input logic [spq_pkg::VALUE_W-1:0] val,
			input logic [spq_pkg::RANK_W-1:0] rank);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {rank, val};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(queue_op(op, val, rank));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_boundaries();
		int i;
		send_beat(spq_pkg::FUNC_PEEK, 32'h1234_5678, 16'h0000);
		send_beat(spq_pkg::FUNC_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
		send_beat(FUNC_NOP, 32'hDEAD_BEEF, 16'h5555);
		send_beat(spq_pkg::FUNC_ENQ, 32'h7FFF_FFFF, 16'hFFFF);
		send_beat(spq_pkg::FUNC_ENQ, 32'h8000_0000, 16'h0000);
		send_beat(spq_pkg::FUNC_ENQ, 32'h0000_0000, 16'hFFFF);
		send_beat(spq_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 16'h0000);
		send_beat(spq_pkg::FUNC_ENQ, 32'hAAAA_AAAA, 16'h8000);
		// equal priorities must leave in arrival order
		for (i = 0; i < 11; i++)
			send_beat(spq_pkg::FUNC_ENQ, $urandom, 16'h0007);
		// queue is full here, this one is dropped
		send_beat(spq_pkg::FUNC_ENQ, 32'h5555_5555, 16'h0000);
		send_beat(FUNC_NOP, 32'h0F0F_0F0F, 16'h00FF);
		send_beat(spq_pkg::FUNC_PEEK, 32'h0, 16'h0);
		for (i = 0; i < 3; i++)
			send_beat(spq_pkg::FUNC_DEQ, 32'h0, 16'h0);
	endtask

	task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
		int                         i;
		int                         run_left;
		int                         enq_pct;
		int                         pick;
		logic [1:0]                 op;
		logic [spq_pkg::RANK_W-1:0] rank;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		run_left    = 0;
		enq_pct     = 50;
		for (i = 0; i < n_items; i++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(20, 60);
				case ($urandom_range(0, 2))
					0: enq_pct = 85;
					1: enq_pct = 50;
					default: enq_pct = 20;
				endcase
			end
			run_left--;
			pick = $urandom_range(0, 99);
			if (pick < 4)
				op = FUNC_NOP;
			else if (pick < enq_pct)
				op = spq_pkg::FUNC_ENQ;
			else if ($urandom_range(0, 3) == 0)
				op = spq_pkg::FUNC_PEEK;
			else
				op = spq_pkg::FUNC_DEQ;
			case ($urandom_range(0, 3))
				0: rank = spq_pkg::RANK_W'($urandom_range(0, 7));
				1: rank = spq_pkg::RANK_W'($urandom);
				2: rank = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				default: rank = spq_pkg::RANK_W'($urandom_range(100, 110));
			endcase
			send_beat(op, $urandom, rank);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no expectation waiting");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.status) begin
						$error("status expected %0d got %0d", want.status, m_tuser);
						fail_count++;
					end
					if (m_tdata[31:0] !== want.value) begin
						$error("out_value expected %h got %h", want.value, m_tdata[31:0]);
						fail_count++;
					end
					if (m_tdata[47:32] !== want.rank) begin
						$error("out_rank expected %h got %h", want.rank, m_tdata[47:32]);
						fail_count++;
					end
					if (m_tdata[52:48] !== want.fill) begin
						$error("fill expected %0d got %0d", want.fill, m_tdata[52:48]);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = spq_pkg::FUNC_ENQ;
		stored       = 0;
		fail_count   = 0;
		stall_cycles = 0;
		tx_idle_pct  = 8;
		rx_idle_pct  = 71;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_boundaries();
		wait_drained();
		test_random_traffic(225, 8, 71);
		wait_drained();
		test_random_traffic(225, 71, 8);
		wait_drained();
		test_random_traffic(225, 0, 0);
		wait_drained();
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
